>>> hdl/abe_pkg.sv
// Package for the accumulator bytecode executor.
// Holds the store geometry, cell addresses, return kinds and the extended-code length table.
// No dependencies.
package abe_pkg;

    localparam int CELL_WORDS  = 512;
    localparam int XMEM_OFFSET = 256;
    localparam int ADDR_W      = $clog2(CELL_WORDS);

    localparam logic [ADDR_W-1:0] ACC_ADDR  = ADDR_W'(8'hE0);
    localparam logic [ADDR_W-1:0] BREG_ADDR = ADDR_W'(8'hF0);
    localparam logic [ADDR_W-1:0] VRB_ADDR  = ADDR_W'(8'h30);
    localparam logic [ADDR_W-1:0] XMEM_ADDR = ADDR_W'(XMEM_OFFSET);

    // return kinds
    localparam logic [2:0] KIND_RET     = 3'd0;
    localparam logic [2:0] KIND_EXT_RET = 3'd1;
    localparam logic [2:0] KIND_FLT_RET = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    // main opcodes
    localparam logic [7:0] OP_MOVI = 8'h74;
    localparam logic [7:0] OP_MOVD = 8'hE5;
    localparam logic [7:0] OP_STD  = 8'hF5;
    localparam logic [7:0] OP_ADD  = 8'h25;
    localparam logic [7:0] OP_SUB  = 8'h95;
    localparam logic [7:0] OP_AND  = 8'h55;
    localparam logic [7:0] OP_OR   = 8'h45;
    localparam logic [7:0] OP_XOR  = 8'h65;
    localparam logic [7:0] OP_EXT  = 8'hFF;
    localparam logic [7:0] OP_CLRA = 8'hE4;
    localparam logic [7:0] OP_CLRC = 8'hC3;
    localparam logic [7:0] OP_CPL  = 8'hF4;
    localparam logic [7:0] OP_MUL  = 8'hA4;
    localparam logic [7:0] OP_DIV  = 8'h84;
    localparam logic [7:0] OP_RET  = 8'h22;

    // extended opcodes
    localparam logic [7:0] EX_MUL  = 8'h01;
    localparam logic [7:0] EX_DIV  = 8'h02;
    localparam logic [7:0] EX_MOD  = 8'h03;
    localparam logic [7:0] EX_SHL  = 8'h04;
    localparam logic [7:0] EX_SHR  = 8'h05;
    localparam logic [7:0] EX_NEG  = 8'h06;
    localparam logic [7:0] EX_CPL  = 8'h07;
    localparam logic [7:0] EX_SGT  = 8'h08;
    localparam logic [7:0] EX_SLT  = 8'h09;
    localparam logic [7:0] EX_SGE  = 8'h0A;
    localparam logic [7:0] EX_SLE  = 8'h0B;
    localparam logic [7:0] EX_EQ   = 8'h0C;
    localparam logic [7:0] EX_NE   = 8'h0D;
    localparam logic [7:0] EX_RET  = 8'h0E;
    localparam logic [7:0] EX_UGT  = 8'h0F;
    localparam logic [7:0] EX_ULT  = 8'h10;
    localparam logic [7:0] EX_UGE  = 8'h11;
    localparam logic [7:0] EX_ULE  = 8'h12;
    localparam logic [7:0] EX_FRET = 8'h21;
    localparam logic [7:0] EX_LDC  = 8'h22;
    localparam logic [7:0] EX_MEM  = 8'h23;

    localparam logic [7:0] MEMFN_LD = 8'd25;
    localparam logic [7:0] MEMFN_ST = 8'd26;

    function automatic logic ext_known(input logic [7:0] e);
        ext_known = (e >= EX_MUL && e <= EX_ULE) || e == EX_FRET || e == EX_LDC
                    || e == EX_MEM;
    endfunction

    // operand bytes that follow an extended code
    function automatic logic [2:0] ext_need(input logic [7:0] e);
        logic [2:0] n;
        n = 3'd2;
        if (e == EX_SHL || e == EX_SHR || e == EX_RET || e == EX_FRET)
            n = 3'd1;
        else if (e == EX_NEG || e == EX_CPL)
            n = 3'd0;
        else if (e == EX_LDC)
            n = 3'd5;
        else if (e == EX_MEM)
            n = 3'd3;
        ext_need = n;
    endfunction

endpackage

>>> hdl/abe_if.sv
// Handshake channels of the bytecode executor: code bytes in, return values out.
// Depends on nothing.
interface abe_code_if;
    logic               valid;
    logic               ready;
    logic [7:0]         code_byte;
    logic               first_byte;
    logic               last_byte;
    logic signed [63:0] argument;

    modport source (output valid, code_byte, first_byte, last_byte, argument, input ready);
    modport sink   (input valid, code_byte, first_byte, last_byte, argument, output ready);
endinterface

interface abe_ret_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] return_value;
    logic [2:0]         return_kind;

    modport source (output valid, return_value, return_kind, input ready);
    modport sink   (input valid, return_value, return_kind, output ready);
endinterface

>>> hdl/abe_div.sv
// Restoring 8-bit divider, one quotient bit per cycle.
// Used by the executor for DIV AB and the extended divide and modulo.
module abe_div (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] dividend,
    input  logic [7:0] divisor,
    output logic       done,
    output logic [7:0] quot,
    output logic [7:0] rem
);
    import abe_pkg::*;

    logic [7:0] quo_reg, rem_reg, dvs_reg;
    logic [3:0] cnt_reg;
    logic       busy_reg, done_reg;
    logic [8:0] shifted, diff;

    assign shifted = {rem_reg, quo_reg[7]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd8;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[8])
            begin
                rem_reg <= diff[7:0];
                quo_reg <= {quo_reg[6:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[7:0];
                quo_reg <= {quo_reg[6:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;
endmodule

>>> hdl/accumulator_bytecode_executor_top.sv
// Top level of the accumulator bytecode executor: sequencer, cell store and output register.
// Depends on abe_pkg, abe_if and abe_div.
//
//   channel   dir   contents                                         taken when
//   code      in    code_byte, first_byte, last_byte, argument       valid && ready
//   result    out   return_value, return_kind                        valid && ready
//
// A code byte passes through decode, two store reads, execute and finish; the single
// store port sets this. Divides wait in S_DIVW for the shared divider, a byte load
// passes S_MEM1 and S_MEM2. A first byte adds a clearing pass over the store before decode.
// Reset leaves the block idle until a first byte; code.ready is low while a byte is worked
// on; a result held in the output register stalls the next result, and code input with it.
module accumulator_bytecode_executor_top (
    input  logic   clk,
    input  logic   rst_n,
    abe_code_if.sink   code,
    abe_ret_if.source  result
);
    import abe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_ARG, S_DEC, S_RD2, S_RD3, S_EXEC, S_DIVW, S_WB2,
        S_MEM1, S_MEM2, S_END, S_ENDQ, S_OUT
    } state_t;

    typedef enum logic [4:0] {
        A_NOP, A_CLRA, A_CPL, A_MUL, A_DIVAB, A_RETA, A_UNK, A_MOVI, A_MOVD, A_STD,
        A_ADD, A_SUB, A_AND, A_OR, A_XOR, A_ENEG, A_ECPL, A_EMUL, A_EDIV, A_EMOD,
        A_ESHL, A_ESHR, A_ERET, A_FRET, A_LDC, A_MEM, A_CMP
    } act_t;

    typedef enum logic [1:0] {D_AB, D_QUO, D_REM} divmode_t;

    logic [63:0] mem [CELL_WORDS];
    logic [63:0] mem_q;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic [63:0] mem_wdata;
    logic        mem_we;

    state_t      state_reg;
    act_t        act_reg;
    divmode_t    dmode_reg;
    logic [7:0]  byte_reg, pend_op_reg, pend_ext_reg, ecode_reg, memx_reg, wb2_reg;
    logic [2:0]  cnt_reg, kind_reg;
    logic [31:0] ops_reg;
    logic        fin_reg, last_reg, res_reg;
    logic [63:0] arg_reg, op1_reg, op2_reg, val_reg;
    logic [ADDR_W-1:0] clr_reg, addr2_reg;
    logic        ovalid_reg;
    logic [63:0] oval_reg;
    logic [2:0]  okind_reg;

    // decode
    act_t        dec_act;
    logic [ADDR_W-1:0] dec_a1, dec_a2, vra, vrb;
    logic        dec_set_pend, dec_set_ext, dec_acc_op;
    logic [2:0]  need;

    // execute
    logic        ex_we, ex_wb2, ex_res, ex_div, ex_mem1;
    logic [ADDR_W-1:0] ex_waddr;
    logic [63:0] ex_wdata, ex_val;
    logic [7:0]  ex_b;
    logic [2:0]  ex_kind;
    divmode_t    ex_dmode;
    logic [15:0] prod;
    logic [7:0]  cx, cy;
    logic        cr;

    logic        div_done;
    logic [7:0]  div_q, div_r;

    assign vra  = VRB_ADDR + ADDR_W'(ops_reg[7:0]);
    assign vrb  = VRB_ADDR + ADDR_W'(byte_reg);
    assign need = ext_need(pend_ext_reg);

    always_comb
    begin
        dec_act      = A_NOP;
        dec_a1       = ACC_ADDR;
        dec_a2       = ACC_ADDR;
        dec_set_pend = 1'b0;
        dec_set_ext  = 1'b0;
        dec_acc_op   = 1'b0;
        if (pend_op_reg == 8'h00)
        begin
            unique case (byte_reg)
                OP_MOVI, OP_MOVD, OP_STD, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_EXT:
                    dec_set_pend = 1'b1;
                OP_CLRA: dec_act = A_CLRA;
                OP_CLRC: dec_act = A_NOP;
                OP_CPL:  dec_act = A_CPL;
                OP_MUL:  begin dec_act = A_MUL;   dec_a2 = BREG_ADDR; end
                OP_DIV:  begin dec_act = A_DIVAB; dec_a2 = BREG_ADDR; end
                OP_RET:  dec_act = A_RETA;
                default: dec_act = A_UNK;
            endcase
        end
        else if (pend_op_reg != OP_EXT)
        begin
            dec_a1 = ADDR_W'(byte_reg);
            unique case (pend_op_reg)
                OP_MOVI: dec_act = A_MOVI;
                OP_MOVD: dec_act = A_MOVD;
                OP_STD:  dec_act = A_STD;
                OP_ADD:  dec_act = A_ADD;
                OP_SUB:  dec_act = A_SUB;
                OP_AND:  dec_act = A_AND;
                OP_OR:   dec_act = A_OR;
                default: dec_act = A_XOR;
            endcase
        end
        else if (pend_ext_reg == 8'h00)
        begin
            if (!ext_known(byte_reg))
                dec_act = A_UNK;
            else if (byte_reg == EX_NEG)
                dec_act = A_ENEG;
            else if (byte_reg == EX_CPL)
                dec_act = A_ECPL;
            else
                dec_set_ext = 1'b1;
        end
        else if (({1'b0, cnt_reg} + 4'd1) < {1'b0, need})
        begin
            dec_acc_op = 1'b1;
        end
        else
        begin
            dec_a1 = vra;
            dec_a2 = vrb;
            unique case (pend_ext_reg)
                EX_MUL: dec_act = A_EMUL;
                EX_DIV: dec_act = A_EDIV;
                EX_MOD: dec_act = A_EMOD;
                EX_SHL: begin dec_act = A_ESHL; dec_a1 = ACC_ADDR; end
                EX_SHR: begin dec_act = A_ESHR; dec_a1 = ACC_ADDR; end
                EX_RET: begin dec_act = A_ERET; dec_a1 = vrb; end
                EX_FRET: begin dec_act = A_FRET; dec_a1 = ADDR_W'(byte_reg); end
                EX_LDC: dec_act = A_LDC;
                EX_MEM:
                begin
                    dec_act = A_MEM;
                    dec_a1  = ADDR_W'(ops_reg[15:8]);
                    dec_a2  = ADDR_W'(byte_reg);
                end
                EX_SGT, EX_SLT, EX_SGE, EX_SLE, EX_EQ, EX_NE, EX_UGT, EX_ULT, EX_UGE,
                EX_ULE: dec_act = A_CMP;
                default: dec_act = A_UNK;
            endcase
        end
    end

    // compare on the low bytes; signed forms flip the sign bit
    always_comb
    begin
        cx = op1_reg[7:0];
        cy = op2_reg[7:0];
        if (ecode_reg >= EX_SGT && ecode_reg <= EX_SLE)
        begin
            cx[7] = ~cx[7];
            cy[7] = ~cy[7];
        end
        case (ecode_reg)
            EX_SGT, EX_UGT: cr = cx > cy;
            EX_SLT, EX_ULT: cr = cx < cy;
            EX_SGE, EX_UGE: cr = cx >= cy;
            EX_SLE, EX_ULE: cr = cx <= cy;
            EX_EQ:          cr = cx == cy;
            default:        cr = cx != cy;
        endcase
    end

    assign prod = op1_reg[7:0] * op2_reg[7:0];

    always_comb
    begin
        ex_we    = 1'b0;
        ex_waddr = ACC_ADDR;
        ex_wdata = '0;
        ex_wb2   = 1'b0;
        ex_b     = '0;
        ex_res   = 1'b0;
        ex_kind  = KIND_UNKNOWN;
        ex_val   = '0;
        ex_div   = 1'b0;
        ex_dmode = D_AB;
        ex_mem1  = 1'b0;
        unique case (act_reg)
            A_NOP: ;
            A_CLRA: ex_we = 1'b1;
            A_CPL, A_ECPL: begin ex_we = 1'b1; ex_wdata = {56'd0, ~op1_reg[7:0]}; end
            A_ENEG: begin ex_we = 1'b1; ex_wdata = {56'd0, 8'd0 - op1_reg[7:0]}; end
            A_MUL:
            begin
                ex_we    = 1'b1;
                ex_wdata = {56'd0, prod[7:0]};
                ex_wb2   = 1'b1;
                ex_b     = prod[15:8];
            end
            A_EMUL: begin ex_we = 1'b1; ex_wdata = {56'd0, prod[7:0]}; end
            A_DIVAB:
            begin
                if (op2_reg[7:0] == 8'd0)
                begin
                    ex_we    = 1'b1;
                    ex_wdata = 64'hFF;
                    ex_wb2   = 1'b1;
                    ex_b     = 8'hFF;
                end
                else
                    ex_div = 1'b1;
            end
            A_EDIV, A_EMOD:
            begin
                ex_dmode = (act_reg == A_EDIV) ? D_QUO : D_REM;
                if (op2_reg[7:0] == 8'd0)
                    ex_we = 1'b1;
                else
                    ex_div = 1'b1;
            end
            A_RETA, A_ERET:
            begin
                ex_res  = 1'b1;
                ex_kind = (act_reg == A_RETA) ? KIND_RET : KIND_EXT_RET;
                ex_val  = {{56{op1_reg[7]}}, op1_reg[7:0]};
            end
            A_FRET:
            begin
                ex_res  = 1'b1;
                ex_kind = KIND_FLT_RET;
                ex_val  = {{32{op1_reg[31]}}, op1_reg[31:0]};
            end
            A_UNK: ex_res = 1'b1;
            A_MOVI: begin ex_we = 1'b1; ex_wdata = {56'd0, byte_reg}; end
            A_MOVD: begin ex_we = 1'b1; ex_wdata = op1_reg; end
            A_STD:
            begin
                ex_we    = 1'b1;
                ex_waddr = ADDR_W'(byte_reg);
                ex_wdata = op2_reg;
            end
            A_ADD: begin ex_we = 1'b1; ex_wdata = {56'd0, op2_reg[7:0] + op1_reg[7:0]}; end
            A_SUB: begin ex_we = 1'b1; ex_wdata = {56'd0, op2_reg[7:0] - op1_reg[7:0]}; end
            A_AND: begin ex_we = 1'b1; ex_wdata = {56'd0, op2_reg[7:0] & op1_reg[7:0]}; end
            A_OR:  begin ex_we = 1'b1; ex_wdata = {56'd0, op2_reg[7:0] | op1_reg[7:0]}; end
            A_XOR: begin ex_we = 1'b1; ex_wdata = {56'd0, op2_reg[7:0] ^ op1_reg[7:0]}; end
            A_ESHL:
            begin
                ex_we = 1'b1;
                if (op2_reg[7:3] == 5'd0)
                    ex_wdata = {56'd0, op1_reg[7:0] << op2_reg[2:0]};
            end
            A_ESHR:
            begin
                ex_we = 1'b1;
                if (op2_reg[7:3] == 5'd0)
                    ex_wdata = {56'd0, op1_reg[7:0] >> op2_reg[2:0]};
            end
            A_LDC:
            begin
                ex_we    = 1'b1;
                ex_waddr = ADDR_W'(byte_reg);
                ex_wdata = {32'd0, ops_reg};
            end
            A_MEM:
            begin
                if (ops_reg[7:0] == MEMFN_LD)
                    ex_mem1 = 1'b1;
                else if (ops_reg[7:0] == MEMFN_ST)
                begin
                    ex_we    = 1'b1;
                    ex_waddr = XMEM_ADDR + ADDR_W'(op1_reg[7:0]);
                    ex_wdata = {56'd0, op2_reg[7:0]};
                end
            end
            A_CMP: begin ex_we = 1'b1; ex_wdata = {63'd0, cr}; end
            default: ;
        endcase
    end

    abe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_EXEC && ex_div),
        .dividend (op1_reg[7:0]),
        .divisor  (op2_reg[7:0]),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // store port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ACC_ADDR;
        mem_wdata = '0;
        case (state_reg)
            S_CLEAR: begin mem_we = 1'b1; mem_waddr = clr_reg; end
            S_ARG:   begin mem_we = 1'b1; mem_waddr = VRB_ADDR; mem_wdata = arg_reg; end
            S_EXEC:  begin mem_we = ex_we; mem_waddr = ex_waddr; mem_wdata = ex_wdata; end
            S_DIVW:
            begin
                mem_we    = div_done;
                mem_wdata = {56'd0, (dmode_reg == D_REM) ? div_r : div_q};
            end
            S_WB2:
            begin
                mem_we    = 1'b1;
                mem_waddr = BREG_ADDR;
                mem_wdata = {56'd0, wb2_reg};
            end
            S_MEM2:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(byte_reg);
                mem_wdata = {56'd0, mem_q[7:0]};
            end
            default: ;
        endcase
        case (state_reg)
            S_RD2:   mem_raddr = addr2_reg;
            S_MEM1:  mem_raddr = XMEM_ADDR + ADDR_W'(memx_reg);
            S_END:   mem_raddr = ACC_ADDR;
            default: mem_raddr = dec_a1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            act_reg      <= A_NOP;
            dmode_reg    <= D_AB;
            pend_op_reg  <= '0;
            pend_ext_reg <= '0;
            cnt_reg      <= '0;
            ops_reg      <= '0;
            fin_reg      <= 1'b1;
            res_reg      <= 1'b0;
            clr_reg      <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            // S_OUT reloads the output register itself
            if (ovalid_reg && result.ready && state_reg != S_OUT)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (code.valid)
                    begin
                        byte_reg <= code.code_byte;
                        last_reg <= code.last_byte;
                        arg_reg  <= code.argument;
                        res_reg  <= 1'b0;
                        if (code.first_byte)
                        begin
                            pend_op_reg  <= '0;
                            pend_ext_reg <= '0;
                            cnt_reg      <= '0;
                            ops_reg      <= '0;
                            fin_reg      <= 1'b0;
                            clr_reg      <= '0;
                            state_reg    <= S_CLEAR;
                        end
                        else if (!fin_reg)
                            state_reg <= S_DEC;
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ADDR_W'(CELL_WORDS - 1))
                        state_reg <= S_ARG;
                end
                S_ARG: state_reg <= S_DEC;
                S_DEC:
                begin
                    act_reg   <= dec_act;
                    addr2_reg <= dec_a2;
                    ecode_reg <= pend_ext_reg;
                    if (dec_set_pend)
                        pend_op_reg <= byte_reg;
                    if (dec_set_ext)
                    begin
                        pend_ext_reg <= byte_reg;
                        cnt_reg      <= '0;
                        ops_reg      <= '0;
                    end
                    if (dec_acc_op)
                    begin
                        ops_reg <= ops_reg | ({24'd0, byte_reg} << {cnt_reg[1:0], 3'b000});
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    op1_reg   <= mem_q;
                    state_reg <= S_RD3;
                end
                S_RD3:
                begin
                    op2_reg   <= mem_q;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (act_reg != A_NOP)
                    begin
                        pend_op_reg  <= '0;
                        pend_ext_reg <= '0;
                        cnt_reg      <= '0;
                        ops_reg      <= '0;
                    end
                    res_reg   <= ex_res;
                    kind_reg  <= ex_kind;
                    val_reg   <= ex_val;
                    wb2_reg   <= ex_b;
                    memx_reg  <= op1_reg[7:0];
                    dmode_reg <= ex_dmode;
                    if (ex_div)
                        state_reg <= S_DIVW;
                    else if (ex_mem1)
                        state_reg <= S_MEM1;
                    else if (ex_wb2)
                        state_reg <= S_WB2;
                    else
                        state_reg <= S_END;
                end
                S_DIVW:
                begin
                    wb2_reg <= div_r;
                    if (div_done)
                        state_reg <= (dmode_reg == D_AB) ? S_WB2 : S_END;
                end
                S_WB2:  state_reg <= S_END;
                S_MEM1: state_reg <= S_MEM2;
                S_MEM2: state_reg <= S_END;
                S_END:
                begin
                    if (res_reg)
                        state_reg <= S_OUT;
                    else if (last_reg)
                        state_reg <= S_ENDQ;
                    else
                        state_reg <= S_IDLE;
                end
                S_ENDQ:
                begin
                    kind_reg  <= KIND_END;
                    val_reg   <= {{56{mem_q[7]}}, mem_q[7:0]};
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ovalid_reg || result.ready)
                    begin
                        ovalid_reg   <= 1'b1;
                        oval_reg     <= val_reg;
                        okind_reg    <= kind_reg;
                        fin_reg      <= 1'b1;
                        pend_op_reg  <= '0;
                        pend_ext_reg <= '0;
                        cnt_reg      <= '0;
                        ops_reg      <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign code.ready          = (state_reg == S_IDLE);
    assign result.valid        = ovalid_reg;
    assign result.return_value = oval_reg;
    assign result.return_kind  = okind_reg;
endmodule
